// File: hw/rtl/frt_pkg.sv
package frt_pkg;

	localparam int SESSIONS      = 8;
	localparam int MAX_FRAGMENTS = 16;
	localparam int SLOT_W        = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
	localparam int FIDX_W        = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
	localparam int CNT_W         = $clog2(MAX_FRAGMENTS + 1);
	localparam int PIECE_DEPTH   = SESSIONS * MAX_FRAGMENTS;
	localparam int PIECE_AW      = SLOT_W + FIDX_W;
	localparam logic [7:0] DEFAULT_BUDGET = 8'd10;

	// operation codes
	localparam logic [1:0] OP_ALLOC  = 2'd0;
	localparam logic [1:0] OP_RECORD = 2'd1;
	localparam logic [1:0] OP_ACK    = 2'd2;

	// result kinds
	localparam logic [2:0] K_ALLOCATED = 3'd0;
	localparam logic [2:0] K_UNKNOWN   = 3'd1;
	localparam logic [2:0] K_STORED    = 3'd2;
	localparam logic [2:0] K_DELIVER   = 3'd3;
	localparam logic [2:0] K_RESEND    = 3'd4;
	localparam logic [2:0] K_DROPPED   = 3'd5;
	localparam logic [2:0] K_REJECTED  = 3'd6;

	typedef struct packed {
		logic [4:0]               expected;
		logic [15:0]              total;
		logic [MAX_FRAGMENTS-1:0] present;
		logic [7:0]               retries;
	} slot_rec_t;

	// key table update
	typedef struct packed {
		logic              set;
		logic              clr;
		logic              arm;
		logic [SLOT_W-1:0] slot;
		logic [31:0]       addr;
		logic [31:0]       msg;
	} key_cmd_t;

	// key table lookup answer
	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] hit_slot;
		logic              free_ok;
		logic [SLOT_W-1:0] free_slot;
	} lookup_t;

	function automatic logic [MAX_FRAGMENTS-1:0] low_mask(input logic [4:0] n);
		logic [MAX_FRAGMENTS:0] m;
		m = (MAX_FRAGMENTS+1)'(1) << n;
		return MAX_FRAGMENTS'(m - (MAX_FRAGMENTS+1)'(1));
	endfunction

endpackage

// File: hw/rtl/frt_if.sv
interface frt_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [31:0] source_ip;
	logic [31:0] remote_id;
	logic [4:0]  fragment_total;
	logic [15:0] message_length;
	logic [3:0]  fragment_index;
	logic [15:0] fragment_length;

	modport source (output valid, operation, source_ip, remote_id, fragment_total,
		message_length, fragment_index, fragment_length, input ready);
	modport sink (input valid, operation, source_ip, remote_id, fragment_total,
		message_length, fragment_index, fragment_length, output ready);
endinterface

interface frt_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [2:0]  session_slot;
	logic [3:0]  frag_number;
	logic [15:0] length_value;
	logic [15:0] whole_length;
	logic        last;

	modport source (output valid, kind, session_slot, frag_number, length_value,
		whole_length, last, input ready);
	modport sink (input valid, kind, session_slot, frag_number, length_value,
		whole_length, last, output ready);
endinterface

// File: hw/rtl/frt_key_table.sv
module frt_key_table (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [31:0]                         addr,
	input  logic [31:0]                         msg,
	input  frt_pkg::key_cmd_t                   cmd,
	output frt_pkg::lookup_t                    look,
	output logic [frt_pkg::SESSIONS-1:0]        armed
);

	logic [frt_pkg::SESSIONS-1:0] valid_q;
	logic [frt_pkg::SESSIONS-1:0] armed_q;
	logic [31:0]                  addr_q [frt_pkg::SESSIONS];
	logic [31:0]                  msg_q  [frt_pkg::SESSIONS];

	// update valid and armed flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			armed_q <= '0;
		end else begin
			if (cmd.set) begin
				valid_q[cmd.slot] <= 1'b1;
				armed_q[cmd.slot] <= 1'b0;
			end
			if (cmd.clr) begin
				valid_q[cmd.slot] <= 1'b0;
				armed_q[cmd.slot] <= 1'b0;
			end
			if (cmd.arm) begin
				armed_q[cmd.slot] <= 1'b1;
			end
		end
	end

	// store keys of a new session
	always_ff @(posedge clk) begin
		if (cmd.set) begin
			addr_q[cmd.slot] <= cmd.addr;
			msg_q[cmd.slot]  <= cmd.msg;
		end
	end

	// match all slots, lowest index wins
	always_comb begin
		look = '0;
		for (int s = frt_pkg::SESSIONS - 1; s >= 0; s--) begin
			if (valid_q[s] && addr_q[s] == addr && msg_q[s] == msg) begin
				look.hit      = 1'b1;
				look.hit_slot = frt_pkg::SLOT_W'(s);
			end
			if (!valid_q[s]) begin
				look.free_ok   = 1'b1;
				look.free_slot = frt_pkg::SLOT_W'(s);
			end
		end
	end

	assign armed = armed_q;

endmodule

// File: hw/rtl/frt_piece_ram.sv
module frt_piece_ram #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hw/rtl/fragment_reassembly_table.sv
// Fragment reassembly session table. Takes one transaction on req at a time and
// answers with one or more transactions on rsp, the final one marked by last.
// Allocate, record, unknown-session and reject items pass from acceptance to
// the next acceptance through latch, key match together with the slot memory
// read, then the result. An acknowledge of a complete session adds, per
// delivered fragment, a fragment length memory read, then output; a resend
// round steps through each fragment index up to the last missing index. A new
// transaction on req is taken once the previous one has issued its last
// result; the result register lets it wait on rsp without holding up req
// beyond that.
module fragment_reassembly_table (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             budget_we,
	input  logic [7:0]       budget_wdata,
	frt_in_if.sink           req,
	frt_out_if.source        rsp
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOOK = 3'd1;
	localparam logic [2:0] ST_EXEC = 3'd2;
	localparam logic [2:0] ST_DRD  = 3'd3;
	localparam logic [2:0] ST_DOUT = 3'd4;
	localparam logic [2:0] ST_RSND = 3'd5;

	logic [2:0]  state_q, state_d;
	logic [7:0]  budget_q;

	logic [1:0]  op_q;
	logic [31:0] ip_q;
	logic [31:0] id_q;
	logic [4:0]  ftot_q;
	logic [15:0] mlen_q;
	logic [frt_pkg::FIDX_W-1:0] fidx_q;
	logic [15:0] flen_q;

	frt_pkg::lookup_t  look, look_q;
	frt_pkg::key_cmd_t kcmd;
	logic [frt_pkg::SESSIONS-1:0] armed;

	frt_pkg::slot_rec_t slot_mem [frt_pkg::SESSIONS];
	frt_pkg::slot_rec_t slot_rd_q;
	frt_pkg::slot_rec_t slot_wd;
	logic               slot_we;
	logic [frt_pkg::SLOT_W-1:0] slot_wa;

	logic [frt_pkg::FIDX_W-1:0] idx_q, idx_d;
	logic [7:0]  retries_q, retries_d;

	logic        p_we, p_re;
	logic [frt_pkg::PIECE_AW-1:0] p_waddr, p_raddr;
	logic [15:0] p_rdata;

	logic        emit, can_emit;
	logic [2:0]  e_kind;
	logic [2:0]  e_slot;
	logic [3:0]  e_frag;
	logic [15:0] e_len;
	logic [15:0] e_whole;
	logic        e_last;

	logic [frt_pkg::MAX_FRAGMENTS-1:0] need, missing, above;
	logic [frt_pkg::CNT_W-1:0]         idx_ext;
	logic [7:0]  cur_retries;

	frt_key_table u_keys (
		.clk    (clk),
		.arst_n (arst_n),
		.addr   (ip_q),
		.msg    (id_q),
		.cmd    (kcmd),
		.look   (look),
		.armed  (armed)
	);

	frt_piece_ram #(
		.DEPTH (frt_pkg::PIECE_DEPTH),
		.WIDTH (16)
	) u_piece (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (flen_q),
		.re    (p_re),
		.raddr (p_raddr),
		.rdata (p_rdata)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign can_emit  = !rsp.valid || rsp.ready;

	// hold the budget register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= frt_pkg::DEFAULT_BUDGET;
		end else if (budget_we) begin
			budget_q <= budget_wdata;
		end
	end

	// latch the accepted transaction
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q   <= req.operation;
			ip_q   <= req.source_ip;
			id_q   <= req.remote_id;
			ftot_q <= req.fragment_total;
			mlen_q <= req.message_length;
			fidx_q <= req.fragment_index;
			flen_q <= req.fragment_length;
		end
		if (state_q == ST_LOOK) begin
			look_q <= look;
		end
		idx_q     <= idx_d;
		retries_q <= retries_d;
	end

	// slot memory: read at the matched slot, write back after modify
	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_wa] <= slot_wd;
		end
		if (state_q == ST_LOOK) begin
			slot_rd_q <= slot_mem[look.hit_slot];
		end
	end

	assign need        = frt_pkg::low_mask(slot_rd_q.expected);
	assign missing     = need & ~slot_rd_q.present;
	assign idx_ext     = frt_pkg::CNT_W'(idx_q);
	assign above       = missing >> (idx_ext + frt_pkg::CNT_W'(1));
	assign cur_retries = armed[look_q.hit_slot] ? slot_rd_q.retries : budget_q;
	assign p_waddr     = {look_q.hit_slot, fidx_q};
	assign p_raddr     = {look_q.hit_slot, idx_q};

	// sequence one transaction
	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		retries_d = retries_q;
		kcmd      = '0;
		kcmd.slot = look_q.hit_slot;
		kcmd.addr = ip_q;
		kcmd.msg  = id_q;
		slot_we   = 1'b0;
		slot_wa   = look_q.hit_slot;
		slot_wd   = slot_rd_q;
		p_we      = 1'b0;
		p_re      = 1'b0;
		emit      = 1'b0;
		e_kind    = frt_pkg::K_REJECTED;
		e_slot    = '0;
		e_frag    = '0;
		e_len     = '0;
		e_whole   = '0;
		e_last    = 1'b1;

		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (can_emit) begin
					state_d = ST_IDLE;
					emit    = 1'b1;
					case (op_q)
						frt_pkg::OP_ALLOC: begin
							if (look_q.hit) begin
								e_kind = frt_pkg::K_ALLOCATED;
								e_slot = 3'(look_q.hit_slot);
							end else if (ftot_q == 5'd0 ||
								ftot_q > 5'(frt_pkg::MAX_FRAGMENTS) || !look_q.free_ok) begin
								e_kind = frt_pkg::K_REJECTED;
							end else begin
								e_kind           = frt_pkg::K_ALLOCATED;
								e_slot           = 3'(look_q.free_slot);
								kcmd.set         = 1'b1;
								kcmd.slot        = look_q.free_slot;
								slot_we          = 1'b1;
								slot_wa          = look_q.free_slot;
								slot_wd.expected = ftot_q;
								slot_wd.total    = mlen_q;
								slot_wd.present  = '0;
							end
						end
						frt_pkg::OP_RECORD: begin
							if (!look_q.hit) begin
								e_kind = frt_pkg::K_UNKNOWN;
							end else if (5'(fidx_q) >= slot_rd_q.expected) begin
								e_kind = frt_pkg::K_REJECTED;
								e_slot = 3'(look_q.hit_slot);
								e_frag = 4'(fidx_q);
							end else begin
								e_kind  = frt_pkg::K_STORED;
								e_slot  = 3'(look_q.hit_slot);
								e_frag  = 4'(fidx_q);
								e_len   = flen_q;
								p_we    = 1'b1;
								slot_we = 1'b1;
								slot_wd.present[fidx_q] = 1'b1;
							end
						end
						frt_pkg::OP_ACK: begin
							if (!look_q.hit) begin
								e_kind = frt_pkg::K_UNKNOWN;
							end else if (missing == '0) begin
								emit    = 1'b0;
								idx_d   = '0;
								state_d = ST_DRD;
							end else if (cur_retries != 8'd0) begin
								emit      = 1'b0;
								idx_d     = '0;
								retries_d = cur_retries;
								state_d   = ST_RSND;
							end else begin
								e_kind   = frt_pkg::K_DROPPED;
								e_slot   = 3'(look_q.hit_slot);
								kcmd.clr = 1'b1;
							end
						end
						default: begin
							e_kind = frt_pkg::K_REJECTED;
						end
					endcase
				end
			end
			ST_DRD: begin
				p_re    = 1'b1;
				state_d = ST_DOUT;
			end
			ST_DOUT: begin
				if (can_emit) begin
					emit    = 1'b1;
					e_kind  = frt_pkg::K_DELIVER;
					e_slot  = 3'(look_q.hit_slot);
					e_frag  = 4'(idx_q);
					e_len   = p_rdata;
					e_whole = slot_rd_q.total;
					e_last  = (5'(idx_q) + 5'd1 == slot_rd_q.expected);
					if (e_last) begin
						kcmd.clr = 1'b1;
						state_d  = ST_IDLE;
					end else begin
						idx_d   = idx_q + 1'b1;
						state_d = ST_DRD;
					end
				end
			end
			ST_RSND: begin
				if (!missing[idx_q]) begin
					idx_d = idx_q + 1'b1;
				end else if (can_emit) begin
					emit   = 1'b1;
					e_kind = frt_pkg::K_RESEND;
					e_slot = 3'(look_q.hit_slot);
					e_frag = 4'(idx_q);
					e_last = (above == '0);
					if (e_last) begin
						kcmd.arm        = 1'b1;
						slot_we         = 1'b1;
						slot_wd.retries = retries_q - 8'd1;
						state_d         = ST_IDLE;
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// advance the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// hold the result until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.valid <= 1'b0;
		end else if (emit) begin
			rsp.valid <= 1'b1;
		end else if (rsp.ready) begin
			rsp.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp.kind         <= e_kind;
			rsp.session_slot <= e_slot;
			rsp.frag_number  <= e_frag;
			rsp.length_value <= e_len;
			rsp.whole_length <= e_whole;
			rsp.last         <= e_last;
		end
	end

endmodule

// File: verif/frt_tb_if.sv
`timescale 1ns / 100ps

// item types shared by the stimulus and the checker
package frt_tb_pkg;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] source_ip;
		logic [31:0] remote_id;
		logic [4:0]  fragment_total;
		logic [15:0] message_length;
		logic [3:0]  fragment_index;
		logic [15:0] fragment_length;
	} frag_req_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [2:0]  session_slot;
		logic [3:0]  frag_number;
		logic [15:0] length_value;
		logic [15:0] whole_length;
		logic        last;
	} frag_rsp_t;

	// row of the directed table; has_rsp marks a typed-in first result
	typedef struct {
		frag_req_t   item;
		logic        has_rsp;
		frag_rsp_t   rsp;
	} stim_row_t;
endpackage

// File: verif/fragment_reassembly_table_tb.sv
`timescale 1ns / 100ps

module fragment_reassembly_table_tb;

	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_OFF    = 300;
	localparam logic [1:0] OP_SPARE = 2'd3;

	logic       clk;
	logic       arst_n;
	logic       budget_we;
	logic [7:0] budget_wdata;

	frt_in_if  req ();
	frt_out_if rsp ();

	fragment_reassembly_table dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.budget_we    (budget_we),
		.budget_wdata (budget_wdata),
		.req          (req.sink),
		.rsp          (rsp.source)
	);

	// shadow of the session table
	logic [7:0]  budget_sh;
	logic        slot_used [frt_pkg::SESSIONS];
	logic [31:0] slot_addr [frt_pkg::SESSIONS];
	logic [31:0] slot_msg [frt_pkg::SESSIONS];
	logic [4:0]  slot_frags [frt_pkg::SESSIONS];
	logic [15:0] slot_bytes [frt_pkg::SESSIONS];
	logic [15:0] slot_map [frt_pkg::SESSIONS];
	logic [15:0] slot_piece [frt_pkg::SESSIONS][frt_pkg::MAX_FRAGMENTS];
	logic        slot_armed [frt_pkg::SESSIONS];
	logic [7:0]  slot_retries [frt_pkg::SESSIONS];

	frt_tb_pkg::frag_rsp_t expected_rsp[$];
	int        mismatches;
	int        idle_cycles;
	bit        timed_out;
	bit        hold_rsp;
	bit        held_once;
	bit        rsp_pattern_on;
	int        sent_items;

	// keys used by the random part, so sequences hit live sessions
	logic [31:0] pool_ip [8];
	logic [31:0] pool_id [8];

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic frt_tb_pkg::frag_rsp_t mk_rsp(logic [2:0] k, logic [2:0] s,
		logic [3:0] f, logic [15:0] l, logic [15:0] w);
		frt_tb_pkg::frag_rsp_t r;
		r.kind = k;
		r.session_slot = s;
		r.frag_number = f;
		r.length_value = l;
		r.whole_length = w;
		r.last = 1'b0;
		return r;
	endfunction

	function automatic void reset_shadow();
		budget_sh = frt_pkg::DEFAULT_BUDGET;
		for (int s = 0; s < frt_pkg::SESSIONS; s++) begin
			slot_used[s] = 1'b0;
			slot_armed[s] = 1'b0;
			slot_map[s] = '0;
		end
	endfunction

	// work out the results of one accepted transaction and update the shadow
	function automatic void predict_table(frt_tb_pkg::frag_req_t it);
		frt_tb_pkg::frag_rsp_t outs[$];
		int        hit;
		int        fr;
		hit = -1;
		fr = -1;
		for (int s = frt_pkg::SESSIONS - 1; s >= 0; s--) begin
			if (slot_used[s] && slot_addr[s] == it.source_ip && slot_msg[s] == it.remote_id)
				hit = s;
			if (!slot_used[s])
				fr = s;
		end
		case (it.operation)
			frt_pkg::OP_ALLOC: begin
				if (hit >= 0)
					outs = {outs, mk_rsp(frt_pkg::K_ALLOCATED, 3'(hit), 0, 0, 0)};
				else if (it.fragment_total == 0 ||
					it.fragment_total > frt_pkg::MAX_FRAGMENTS || fr < 0)
					outs = {outs, mk_rsp(frt_pkg::K_REJECTED, 0, 0, 0, 0)};
				else begin
					slot_used[fr] = 1'b1;
					slot_addr[fr] = it.source_ip;
					slot_msg[fr] = it.remote_id;
					slot_frags[fr] = it.fragment_total;
					slot_bytes[fr] = it.message_length;
					slot_map[fr] = '0;
					slot_armed[fr] = 1'b0;
					outs = {outs, mk_rsp(frt_pkg::K_ALLOCATED, 3'(fr), 0, 0, 0)};
				end
			end
			frt_pkg::OP_RECORD: begin
				if (hit < 0)
					outs = {outs, mk_rsp(frt_pkg::K_UNKNOWN, 0, 0, 0, 0)};
				else if (it.fragment_index >= slot_frags[hit])
					outs = {outs, mk_rsp(frt_pkg::K_REJECTED, 3'(hit), it.fragment_index,
						0, 0)};
				else begin
					slot_map[hit][it.fragment_index] = 1'b1;
					slot_piece[hit][it.fragment_index] = it.fragment_length;
					outs = {outs, mk_rsp(frt_pkg::K_STORED, 3'(hit), it.fragment_index,
						it.fragment_length, 0)};
				end
			end
			frt_pkg::OP_ACK: begin
				if (hit < 0)
					outs = {outs, mk_rsp(frt_pkg::K_UNKNOWN, 0, 0, 0, 0)};
				else begin
					logic [15:0] need;
					need = 16'((17'd1 << slot_frags[hit]) - 17'd1);
					if ((slot_map[hit] & need) == need) begin
						for (int i = 0; i < slot_frags[hit]; i++)
							outs = {outs, mk_rsp(frt_pkg::K_DELIVER, 3'(hit), 4'(i),
								slot_piece[hit][i], slot_bytes[hit])};
						slot_used[hit] = 1'b0;
						slot_armed[hit] = 1'b0;
						slot_map[hit] = '0;
					end else begin
						if (!slot_armed[hit]) begin
							slot_armed[hit] = 1'b1;
							slot_retries[hit] = budget_sh;
						end
						if (slot_retries[hit] > 0) begin
							for (int i = 0; i < slot_frags[hit]; i++)
								if (!slot_map[hit][i])
									outs = {outs, mk_rsp(frt_pkg::K_RESEND, 3'(hit), 4'(i),
										0, 0)};
							slot_retries[hit] = slot_retries[hit] - 8'd1;
						end else begin
							outs = {outs, mk_rsp(frt_pkg::K_DROPPED, 3'(hit), 0, 0, 0)};
							slot_used[hit] = 1'b0;
							slot_armed[hit] = 1'b0;
							slot_map[hit] = '0;
						end
					end
				end
			end
			default: outs = {outs, mk_rsp(frt_pkg::K_REJECTED, 0, 0, 0, 0)};
		endcase
		outs[outs.size() - 1].last = 1'b1;
		expected_rsp = {expected_rsp, outs};
	endfunction

	function automatic frt_tb_pkg::frag_req_t mk_req(logic [1:0] op, logic [31:0] ip,
		logic [31:0] id, logic [4:0] tot, logic [15:0] ml, logic [3:0] idx, logic [15:0] fl);
		frt_tb_pkg::frag_req_t r;
		r.operation = op;
		r.source_ip = ip;
		r.remote_id = id;
		r.fragment_total = tot;
		r.message_length = ml;
		r.fragment_index = idx;
		r.fragment_length = fl;
		return r;
	endfunction

	// offer one transaction and hold it until accepted
	task automatic send_item(frt_tb_pkg::frag_req_t it);
		req.valid <= 1'b1;
		req.operation <= it.operation;
		req.source_ip <= it.source_ip;
		req.remote_id <= it.remote_id;
		req.fragment_total <= it.fragment_total;
		req.message_length <= it.message_length;
		req.fragment_index <= it.fragment_index;
		req.fragment_length <= it.fragment_length;
		do
			@(posedge clk);
		while (!(req.valid && req.ready));
		predict_table(it);
		sent_items++;
	endtask

	task automatic idle_req(int n);
		req.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// sender: bursts of random length, random gaps between
	int burst_left;
	task automatic paced_send(frt_tb_pkg::frag_req_t it);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 2) != 0)
				idle_req($urandom_range(1, 8));
		end
		burst_left--;
		send_item(it);
	endtask

	task automatic drain_and_settle();
		req.valid <= 1'b0;
		while (expected_rsp.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_budget(logic [7:0] v);
		budget_we <= 1'b1;
		budget_wdata <= v;
		@(posedge clk);
		budget_we <= 1'b0;
		budget_sh = v;
	endtask

	// receiver: stalls on its own pattern, with an optional long hold
	always @(posedge clk) begin
		if (hold_rsp)
			rsp.ready <= 1'b0;
		else if (rsp_pattern_on)
			rsp.ready <= ($urandom_range(0, 3) != 0);
		else
			rsp.ready <= 1'b1;
	end

	// check each accepted result against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			frt_tb_pkg::frag_rsp_t got;
			frt_tb_pkg::frag_rsp_t want;
			got = mk_rsp(rsp.kind, rsp.session_slot, rsp.frag_number,
				rsp.length_value, rsp.whole_length);
			got.last = rsp.last;
			if (expected_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: kind %0d slot %0d frag %0d", got.kind,
						got.session_slot, got.frag_number);
			end else begin
				want = expected_rsp.pop_front();
				if (got != want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: exp k%0d s%0d f%0d l%0h w%0h L%0b, ",
							"got k%0d s%0d f%0d l%0h w%0h L%0b"},
							want.kind, want.session_slot, want.frag_number, want.length_value,
							want.whole_length, want.last, got.kind, got.session_slot,
							got.frag_number, got.length_value, got.whole_length, got.last);
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("Simulation FAILED");
			$finish;
		end
	end

	// one well-formed session with random content, sometimes broken
	task automatic random_session();
		int          p;
		logic [4:0]  tot;
		logic [31:0] ip;
		logic [31:0] id;
		p = $urandom_range(0, 7);
		ip = pool_ip[p];
		id = pool_id[p];
		tot = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(1, 16))
			: 5'($urandom_range(1, 5));
		paced_send(mk_req(frt_pkg::OP_ALLOC, ip, id, tot, 16'($urandom), 4'($urandom),
			16'($urandom)));
		for (int i = 0; i < tot; i++)
			if ($urandom_range(0, 5) != 0)
				paced_send(mk_req(frt_pkg::OP_RECORD, ip, id, 5'($urandom), 16'($urandom),
					4'(i), 16'($urandom)));
		if ($urandom_range(0, 3) == 0)
			paced_send(mk_req(frt_pkg::OP_RECORD, ip, id, 5'($urandom), 16'($urandom),
				4'($urandom), 16'($urandom)));
		if ($urandom_range(0, 2) != 0)
			paced_send(mk_req(frt_pkg::OP_ACK, ip, id, 5'($urandom), 16'($urandom),
				4'($urandom), 16'($urandom)));
	endtask

	// random noise in op, sizes and index; ip half from the pool, id always from it
	task automatic random_noise();
		paced_send(mk_req(2'($urandom), ($urandom_range(0, 1) ? pool_ip[$urandom_range(0, 7)]
			: 32'($urandom)), pool_id[$urandom_range(0, 7)], 5'($urandom), 16'($urandom),
			4'($urandom), 16'($urandom)));
	endtask

	frt_tb_pkg::stim_row_t dir_rows[$];

	task automatic add_row(frt_tb_pkg::frag_req_t it, logic typed, logic [2:0] k,
		logic [2:0] s);
		frt_tb_pkg::stim_row_t r;
		r.item = it;
		r.has_rsp = typed;
		r.rsp = mk_rsp(k, s, 0, 0, 0);
		dir_rows = {dir_rows, r};
	endtask

	initial begin
		logic [31:0] ones;
		frt_tb_pkg::frag_rsp_t pred;
		ones = 32'hFFFF_FFFF;
		arst_n = 1'b0;
		budget_we = 1'b0;
		budget_wdata = '0;
		req.valid = 1'b0;
		req.operation = frt_pkg::OP_ALLOC;
		req.source_ip = '0;
		req.remote_id = '0;
		req.fragment_total = '0;
		req.message_length = '0;
		req.fragment_index = '0;
		req.fragment_length = '0;
		rsp.ready = 1'b0;
		mismatches = 0;
		idle_cycles = 0;
		timed_out = 1'b0;
		hold_rsp = 1'b0;
		held_once = 1'b0;
		rsp_pattern_on = 1'b0;
		sent_items = 0;
		burst_left = 0;
		reset_shadow();
		for (int i = 0; i < 8; i++) begin
			pool_ip[i] = (i == 7) ? ones : 32'($urandom);
			pool_id[i] = (i == 0) ? 32'd0 : 32'($urandom);
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: unknowns, extremes, rejects, delivery, resend
		add_row(mk_req(frt_pkg::OP_RECORD, 0, 0, 1, 0, 0, 0), 1, frt_pkg::K_UNKNOWN, 0);
		add_row(mk_req(frt_pkg::OP_ACK, ones, ones, 1, 0, 0, 0), 1, frt_pkg::K_UNKNOWN, 0);
		add_row(mk_req(OP_SPARE, ones, ones, 16, 0, 0, 0), 1, frt_pkg::K_REJECTED, 0);
		add_row(mk_req(frt_pkg::OP_ALLOC, 1, 1, 0, 0, 0, 0), 1, frt_pkg::K_REJECTED, 0);
		add_row(mk_req(frt_pkg::OP_ALLOC, 1, 1, 17, 0, 0, 0), 1, frt_pkg::K_REJECTED, 0);
		add_row(mk_req(frt_pkg::OP_ALLOC, 1, 1, 31, 0, 0, 0), 1, frt_pkg::K_REJECTED, 0);
		add_row(mk_req(frt_pkg::OP_ALLOC, ones, ones, 16, 16'hFFFF, 0, 0), 1,
			frt_pkg::K_ALLOCATED, 0);
		add_row(mk_req(frt_pkg::OP_ALLOC, ones, ones, 3, 0, 0, 0), 1,
			frt_pkg::K_ALLOCATED, 0);
		for (int i = 0; i < 16; i++)
			add_row(mk_req(frt_pkg::OP_RECORD, ones, ones, 0, 0, 4'(i),
				(i == 5) ? 16'hFFFF : 16'(i * 37)), 0, 0, 0);
		add_row(mk_req(frt_pkg::OP_RECORD, ones, ones, 0, 0, 4'd15, 16'h0000), 0, 0, 0);
		add_row(mk_req(frt_pkg::OP_ACK, ones, ones, 0, 0, 0, 0), 0, 0, 0);
		add_row(mk_req(frt_pkg::OP_ALLOC, 2, 0, 2, 100, 0, 0), 1, frt_pkg::K_ALLOCATED, 0);
		add_row(mk_req(frt_pkg::OP_RECORD, 2, 0, 0, 0, 4'd2, 5), 0, 0, 0);
		add_row(mk_req(frt_pkg::OP_ACK, 2, 0, 0, 0, 0, 0), 0, 0, 0);
		foreach (dir_rows[i]) begin
			send_item(dir_rows[i].item);
			// typed rows answer with one result, held against the prediction
			if (dir_rows[i].has_rsp) begin
				pred = expected_rsp[expected_rsp.size() - 1];
				if (pred.kind != dir_rows[i].rsp.kind ||
					pred.session_slot != dir_rows[i].rsp.session_slot) begin
					mismatches++;
					if (mismatches <= 10)
						$display("table row %0d: typed kind %0d slot %0d, predicted %0d %0d",
							i, dir_rows[i].rsp.kind, dir_rows[i].rsp.session_slot,
							pred.kind, pred.session_slot);
				end
			end
		end
		drain_and_settle();

		// budget zero on an armed session, then fill the table past full
		write_budget(8'd0);
		send_item(mk_req(frt_pkg::OP_ACK, 2, 0, 0, 0, 0, 0));
		for (int i = 0; i < frt_pkg::SESSIONS + 1; i++)
			send_item(mk_req(frt_pkg::OP_ALLOC, 32'(100 + i), 32'(i), 1, 16'(i), 0, 0));
		for (int i = 0; i < frt_pkg::SESSIONS + 1; i++)
			send_item(mk_req(frt_pkg::OP_ACK, 32'(100 + i), 32'(i), 0, 0, 0, 0));
		drain_and_settle();

		// random part across budget settings, receiver now stalls on a pattern
		rsp_pattern_on = 1'b1;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: write_budget(8'd1);
				1: write_budget(8'd255);
				2: write_budget(8'($urandom_range(2, 4)));
				default: write_budget(8'd0);
			endcase
			while (sent_items < 100 * (phase + 1) + 80) begin
				if ($urandom_range(0, 4) == 0)
					random_noise();
				else
					random_session();
				// long receiver hold while the sender keeps offering
				if (phase == 1 && !held_once) begin
					held_once = 1'b1;
					fork
						begin
							hold_rsp = 1'b1;
							repeat (HOLD_OFF) @(posedge clk);
							hold_rsp = 1'b0;
						end
					join_none
				end
			end
			drain_and_settle();
			// flush open sessions so the next phase starts from a known table
			for (int s = 0; s < frt_pkg::SESSIONS; s++)
				if (slot_used[s])
					send_item(mk_req(frt_pkg::OP_ACK, slot_addr[s], slot_msg[s], 0, 0, 0, 0));
			drain_and_settle();
		end

		if (mismatches == 0 && expected_rsp.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

// File: filelist.f
hw/rtl/frt_pkg.sv
hw/rtl/frt_if.sv
hw/rtl/frt_key_table.sv
hw/rtl/frt_piece_ram.sv
hw/rtl/fragment_reassembly_table.sv
verif/frt_tb_if.sv
verif/fragment_reassembly_table_tb.sv
